@@ rtl/mau_pkg.sv @@
// Shared types and constants for the modular arithmetic unit.
// No dependencies; used by mau_modstep and modular_arithmetic_unit_core.
package mau_pkg;

  localparam int unsigned MODULUS_DEF = 1000000007;

  localparam int OP_W        = 3;
  localparam int OPND_W      = 63;
  localparam int RES_W       = 30;
  localparam int CNT_W       = 6;
  localparam int IN_TDATA_W  = 128;
  localparam int OUT_TDATA_W = 32;

  localparam logic [OP_W-1:0] OP_ADD = 3'd0;
  localparam logic [OP_W-1:0] OP_SUB = 3'd1;
  localparam logic [OP_W-1:0] OP_MUL = 3'd2;
  localparam logic [OP_W-1:0] OP_POW = 3'd3;
  localparam logic [OP_W-1:0] OP_DIV = 3'd4;

  // Controls of the shared modular step unit.
  typedef struct packed {
    logic dbl;
    logic neg;
  } step_ctl_t;

endpackage

@@ rtl/mau_modstep.sv @@
// Shared modular step: y = ((dbl ? 2r : r) mod M + (neg ? -a : a)) mod M.
// Depends on mau_pkg for the control struct and default modulus.
module mau_modstep #(
  parameter int unsigned MODULUS = mau_pkg::MODULUS_DEF,
  localparam int RW = $clog2(MODULUS)
) (
  input  logic [RW-1:0]        r,
  input  logic [RW-1:0]        addend,
  input  mau_pkg::step_ctl_t   ctl,
  output logic [RW-1:0]        y
);

  localparam logic [RW:0] M = (RW+1)'(MODULUS);

  logic [RW:0] dbl_v;
  logic [RW:0] dbl_red;
  logic [RW:0] add_v;
  logic [RW:0] sum_v;

  // Both inputs are below M, so each partial sum stays below 2M and one
  // conditional subtraction brings it back into range.
  always_comb begin
    dbl_v   = ctl.dbl ? {r, 1'b0} : {1'b0, r};
    dbl_red = (dbl_v >= M) ? dbl_v - M : dbl_v;
    add_v   = (ctl.neg && addend != '0) ? M - {1'b0, addend} : {1'b0, addend};
    sum_v   = dbl_red + add_v;
  end

  assign y = (sum_v >= M) ? RW'(sum_v - M) : RW'(sum_v);

endmodule

@@ rtl/modular_arithmetic_unit_core.sv @@
// Top level of the modular arithmetic unit: sequencer, operand registers and
// output register around one shared mau_modstep. Depends on mau_pkg.
//
// Each transfer in carries an operation (add, subtract, multiply, power,
// divide) and two 63-bit operands, and gives exactly one residue modulo
// MODULUS. All arithmetic runs through a single modular double-and-add unit,
// one bit per cycle: both operands are reduced bit by bit, and a modular
// multiply works through the RW bits of its multiplier (RW = clog2(MODULUS),
// 30 by default). Add and subtract use one pass through the unit after
// reduction. Power does up to two multiplies per exponent bit, scanning a
// 63-bit exponent from its low bit: a set bit multiplies the accumulator by
// the running square, which is squared while higher bits remain. Divide raises the divisor to MODULUS-2 and
// multiplies by the dividend; a divisor that reduces to zero gives 0 at once.
// Unused operation codes give 0. The input is not ready while an item is
// being worked on; a finished result waits in the output register, so the
// next item can be taken before the result is collected.
module modular_arithmetic_unit_core #(
  parameter int unsigned MODULUS = mau_pkg::MODULUS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [62:0] operand_a, [125:63] operand_b, [127:126] zero
  input  logic [mau_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // [2:0] req_type
  input  logic [mau_pkg::OP_W-1:0]           s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [29:0] result, [31:30] zero
  output logic [mau_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  localparam int RW    = $clog2(MODULUS);
  localparam int MCW   = (RW > 1) ? $clog2(RW) : 1;
  localparam int OW    = mau_pkg::OPND_W;
  localparam int CW    = mau_pkg::CNT_W;
  localparam int RESW  = mau_pkg::RES_W;
  localparam int OUTW  = mau_pkg::OUT_TDATA_W;
  localparam logic [RW-1:0] ONE     = RW'(1);
  localparam logic [OW-1:0] EXP_INV = OW'(MODULUS - 2);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_RED_A    = 9'b000000010,
    S_RED_B    = 9'b000000100,
    S_DISPATCH = 9'b000001000,
    S_ARITH    = 9'b000010000,
    S_POW_CHK  = 9'b000100000,
    S_POW_SQ   = 9'b001000000,
    S_MUL      = 9'b010000000,
    S_FINISH   = 9'b100000000
  } state_t;

  typedef enum logic [1:0] {
    DST_ACC = 2'd0,
    DST_SQ  = 2'd1,
    DST_RES = 2'd2
  } dst_t;

  state_t                     state;
  state_t                     state_next;
  state_t                     mul_ret;
  dst_t                       mul_dst;
  logic [mau_pkg::OP_W-1:0]   op;
  logic [OW-1:0]              opa;
  logic [OW-1:0]              opb;
  logic [OW-1:0]              expo;
  logic [OW-1:0]              expo_sh;
  logic [RW-1:0]              ra;
  logic [RW-1:0]              rb;
  logic [RW-1:0]              acc;
  logic [RW-1:0]              sq;
  logic [RW-1:0]              mx;
  logic [RW-1:0]              my;
  logic [RW-1:0]              mr;
  logic [RW-1:0]              res;
  logic [CW-1:0]              cnt;
  logic                       is_div;
  logic [RESW-1:0]            out_res;
  logic                       in_xfer;
  logic                       out_load;

  logic [RW-1:0]              u_r;
  logic [RW-1:0]              u_add;
  mau_pkg::step_ctl_t         u_ctl;
  logic [RW-1:0]              u_out;

  assign s_axis_tready = (state == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state == S_FINISH) && (!m_axis_tvalid || m_axis_tready);
  assign expo_sh       = expo >> 1;
  assign m_axis_tdata  = OUTW'(out_res);

  mau_modstep #(
    .MODULUS (MODULUS)
  ) u_step (
    .r      (u_r),
    .addend (u_add),
    .ctl    (u_ctl),
    .y      (u_out)
  );

  // Operand selection for the shared unit.
  always_comb begin
    u_r       = mr;
    u_add     = '0;
    u_ctl.dbl = 1'b0;
    u_ctl.neg = 1'b0;
    case (state)
      S_RED_A: begin
        u_r       = ra;
        u_add     = RW'(opa[cnt]);
        u_ctl.dbl = 1'b1;
      end
      S_RED_B: begin
        u_r       = rb;
        u_add     = RW'(opb[cnt]);
        u_ctl.dbl = 1'b1;
      end
      S_ARITH: begin
        u_r       = ra;
        u_add     = rb;
        u_ctl.neg = (op == mau_pkg::OP_SUB);
      end
      S_MUL: begin
        u_r       = mr;
        u_add     = mx[cnt[MCW-1:0]] ? my : '0;
        u_ctl.dbl = 1'b1;
      end
      default: begin
        u_r = mr;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_xfer) state_next = S_RED_A;
      end
      S_RED_A: begin
        if (cnt == '0) state_next = S_RED_B;
      end
      S_RED_B: begin
        if (cnt == '0) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (op)
          mau_pkg::OP_ADD: state_next = S_ARITH;
          mau_pkg::OP_SUB: state_next = S_ARITH;
          mau_pkg::OP_MUL: state_next = S_MUL;
          mau_pkg::OP_POW: state_next = S_POW_CHK;
          mau_pkg::OP_DIV: state_next = (rb == '0) ? S_FINISH : S_POW_CHK;
          default:         state_next = S_FINISH;
        endcase
      end
      S_ARITH: state_next = S_FINISH;
      S_POW_CHK: begin
        if (expo == '0) begin
          state_next = is_div ? S_MUL : S_FINISH;
        end else begin
          state_next = expo[0] ? S_MUL : S_POW_SQ;
        end
      end
      S_POW_SQ: state_next = (expo_sh != '0) ? S_MUL : S_POW_CHK;
      S_MUL: begin
        if (cnt == '0) state_next = mul_ret;
      end
      S_FINISH: begin
        if (out_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers; a multiply is started by loading mx, my, mr, cnt and
  // naming where the product goes and which state follows.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_xfer) begin
          op  <= s_axis_tuser;
          opa <= s_axis_tdata[OW-1:0];
          opb <= s_axis_tdata[2*OW-1:OW];
          ra  <= '0;
          rb  <= '0;
          cnt <= CW'(OW - 1);
        end
      end
      S_RED_A: begin
        ra  <= u_out;
        cnt <= (cnt == '0) ? CW'(OW - 1) : cnt - 1'b1;
      end
      S_RED_B: begin
        rb  <= u_out;
        cnt <= cnt - 1'b1;
      end
      S_DISPATCH: begin
        acc    <= ONE;
        is_div <= (op == mau_pkg::OP_DIV);
        res    <= '0;
        case (op)
          mau_pkg::OP_MUL: begin
            mx      <= ra;
            my      <= rb;
            mr      <= '0;
            cnt     <= CW'(RW - 1);
            mul_dst <= DST_RES;
            mul_ret <= S_FINISH;
          end
          mau_pkg::OP_POW: begin
            sq   <= ra;
            expo <= opb;
          end
          mau_pkg::OP_DIV: begin
            sq   <= rb;
            expo <= EXP_INV;
          end
          default: begin
            sq <= ra;
          end
        endcase
      end
      S_ARITH: begin
        res <= u_out;
      end
      S_POW_CHK: begin
        if (expo == '0) begin
          if (is_div) begin
            mx      <= ra;
            my      <= acc;
            mr      <= '0;
            cnt     <= CW'(RW - 1);
            mul_dst <= DST_RES;
            mul_ret <= S_FINISH;
          end else begin
            res <= acc;
          end
        end else if (expo[0]) begin
          mx      <= acc;
          my      <= sq;
          mr      <= '0;
          cnt     <= CW'(RW - 1);
          mul_dst <= DST_ACC;
          mul_ret <= S_POW_SQ;
        end
      end
      S_POW_SQ: begin
        expo <= expo_sh;
        // The last squaring is skipped: no exponent bit would use it.
        if (expo_sh != '0) begin
          mx      <= sq;
          my      <= sq;
          mr      <= '0;
          cnt     <= CW'(RW - 1);
          mul_dst <= DST_SQ;
          mul_ret <= S_POW_CHK;
        end
      end
      S_MUL: begin
        mr  <= u_out;
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          case (mul_dst)
            DST_ACC: acc <= u_out;
            DST_SQ:  sq  <= u_out;
            DST_RES: res <= u_out;
            default: res <= u_out;
          endcase
        end
      end
      default: begin
        mr <= mr;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_res <= RESW'(res);
  end

`ifndef SYNTH
  a_res_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (32'(out_res) < MODULUS))
    else $error("result residue not below the modulus");

  a_reduced: assert property (@(posedge clk) disable iff (rst)
    (state == S_DISPATCH) |-> ((32'(ra) < MODULUS) && (32'(rb) < MODULUS)))
    else $error("operand reduction left a value out of range");

  a_mul_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL) |-> ((32'(mr) < MODULUS) && (32'(my) < MODULUS)))
    else $error("multiply step operands out of range");

  a_start: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> ((state == S_RED_A) && (cnt == CW'(OW - 1))))
    else $error("accepted item did not start operand reduction");

  a_load: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (m_axis_tvalid && (out_res == RESW'($past(res)))))
    else $error("finished result not presented on the output");
`endif

endmodule
